### rtl/lateral_shift_hysteresis_arbiter_top_defines.svh
// Assertion macros for the lateral shift hysteresis arbiter checker.
`ifndef LATERAL_SHIFT_HYSTERESIS_ARBITER_TOP_DEFINES_SVH
`define LATERAL_SHIFT_HYSTERESIS_ARBITER_TOP_DEFINES_SVH

// Check a property outside reset.
`define LSHAR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property that also covers the reset cycles.
`define LSHAR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/lshar_pkg.sv
// Shared types and constants of the lateral shift hysteresis arbiter.
package lshar_pkg;

  localparam int DIST_W = 11;
  localparam int ID_W   = 16;
  localparam int GAP_W  = 16;
  localparam int CNT_W  = 9;
  localparam int THR_W  = 8;
  localparam int MARGIN_W = 13;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [1:0] SIDE_NONE  = 2'd0;
  localparam logic [1:0] SIDE_LEFT  = 2'd1;
  localparam logic [1:0] SIDE_RIGHT = 2'd2;

  localparam logic [DIST_W-1:0] MIN_SHIFT_MM = DIST_W'(10);
  localparam logic [CNT_W-1:0]  CNT_MAX      = '1;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_SAFETY_MARGIN = 3'd0;
  localparam logic [2:0] REG_MAX_SHIFT     = 3'd1;
  localparam logic [2:0] REG_ENTER_THR     = 3'd2;
  localparam logic [2:0] REG_RELEASE_THR   = 3'd3;
  localparam logic [2:0] REG_DIRECTION_THR = 3'd4;
  localparam logic [2:0] REG_DECREASE_THR  = 3'd5;

  typedef struct packed {
    logic                    inhibit;
    logic signed [GAP_W-1:0] left_gap_mm;
    logic signed [GAP_W-1:0] right_gap_mm;
    logic [ID_W-1:0]         left_obstacle;
    logic [ID_W-1:0]         right_obstacle;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        shift_side;
    logic [DIST_W-1:0] shift_mm;
    logic [ID_W-1:0]   obstacle_id;
  } out_item_t;

  typedef struct packed {
    logic [MARGIN_W-1:0] safety_margin_mm;
    logic [DIST_W-1:0]   max_shift_mm;
    logic [THR_W-1:0]    enter_threshold;
    logic [THR_W-1:0]    release_threshold;
    logic [THR_W-1:0]    direction_threshold;
    logic [THR_W-1:0]    decrease_threshold;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        side;
    logic [DIST_W-1:0] distance;
    logic [ID_W-1:0]   id;
  } cand_t;

endpackage

### rtl/lshar_cfg.sv
// Configuration register file with APB-style access.
module lshar_cfg import lshar_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.safety_margin_mm    <= MARGIN_W'(500);
      cfg.max_shift_mm        <= DIST_W'(300);
      cfg.enter_threshold     <= THR_W'(5);
      cfg.release_threshold   <= THR_W'(10);
      cfg.direction_threshold <= THR_W'(5);
      cfg.decrease_threshold  <= THR_W'(5);
    end else if (wr_en) begin
      case (reg_idx)
        REG_SAFETY_MARGIN: cfg.safety_margin_mm    <= pwdata[MARGIN_W-1:0];
        REG_MAX_SHIFT:     cfg.max_shift_mm        <= pwdata[DIST_W-1:0];
        REG_ENTER_THR:     cfg.enter_threshold     <= pwdata[THR_W-1:0];
        REG_RELEASE_THR:   cfg.release_threshold   <= pwdata[THR_W-1:0];
        REG_DIRECTION_THR: cfg.direction_threshold <= pwdata[THR_W-1:0];
        REG_DECREASE_THR:  cfg.decrease_threshold  <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SAFETY_MARGIN: prdata = DATA_W'(cfg.safety_margin_mm);
      REG_MAX_SHIFT:     prdata = DATA_W'(cfg.max_shift_mm);
      REG_ENTER_THR:     prdata = DATA_W'(cfg.enter_threshold);
      REG_RELEASE_THR:   prdata = DATA_W'(cfg.release_threshold);
      REG_DIRECTION_THR: prdata = DATA_W'(cfg.direction_threshold);
      REG_DECREASE_THR:  prdata = DATA_W'(cfg.decrease_threshold);
      default:           prdata = '0;
    endcase
  end

endmodule

### rtl/lshar_cand.sv
// Per-side shift computation and candidate side selection.
module lshar_cand import lshar_pkg::*; (
  input  in_item_t item,
  input  cfg_t     cfg,
  output cand_t    cand
);

  localparam int DIFF_W = GAP_W + 2;

  function automatic logic [DIST_W-1:0] clamp_shift(
    input logic [MARGIN_W-1:0] margin,
    input logic [DIST_W-1:0]   max_shift,
    input logic signed [GAP_W-1:0] gap
  );
    logic signed [DIFF_W-1:0] diff;
    logic [DIST_W-1:0]        res;
    diff = $signed({{(DIFF_W-MARGIN_W){1'b0}}, margin})
         - $signed({{(DIFF_W-GAP_W){gap[GAP_W-1]}}, gap});
    if (diff[DIFF_W-1]) begin
      res = '0;
    end else if (diff > $signed({{(DIFF_W-DIST_W){1'b0}}, max_shift})) begin
      res = max_shift;
    end else begin
      res = diff[DIST_W-1:0];
    end
    return res;
  endfunction

  logic [DIST_W-1:0] left_shift;
  logic [DIST_W-1:0] right_shift;
  logic              left_hot;
  logic              right_hot;

  assign left_shift  = clamp_shift(cfg.safety_margin_mm, cfg.max_shift_mm, item.left_gap_mm);
  assign right_shift = clamp_shift(cfg.safety_margin_mm, cfg.max_shift_mm, item.right_gap_mm);
  assign left_hot    = left_shift > MIN_SHIFT_MM;
  assign right_hot   = right_shift > MIN_SHIFT_MM;

  // Only one side may be dangerous; both or neither gives no candidate.
  always_comb begin
    if (left_hot && !right_hot) begin
      cand = '{side: SIDE_LEFT, distance: left_shift, id: item.left_obstacle};
    end else if (right_hot && !left_hot) begin
      cand = '{side: SIDE_RIGHT, distance: right_shift, id: item.right_obstacle};
    end else begin
      cand = '{side: SIDE_NONE, distance: '0, id: '0};
    end
  end

endmodule

### rtl/lshar_debounce.sv
// Held shift status and its four debounce counters.
module lshar_debounce import lshar_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  logic      inhibit,
  input  cand_t     cand,
  input  cfg_t      cfg,
  output out_item_t held
);

  out_item_t        held_next;
  logic [CNT_W-1:0] enter_counter, enter_counter_next;
  logic [CNT_W-1:0] release_counter, release_counter_next;
  logic [CNT_W-1:0] direction_counter, direction_counter_next;
  logic [CNT_W-1:0] decrease_counter, decrease_counter_next;
  logic [CNT_W-1:0] enter_bump, release_bump, direction_bump, decrease_bump;

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? CNT_MAX : c + CNT_W'(1);
  endfunction

  assign enter_bump     = bump(enter_counter);
  assign release_bump   = bump(release_counter);
  assign direction_bump = bump(direction_counter);
  assign decrease_bump  = bump(decrease_counter);

  always_comb begin
    held_next              = held;
    enter_counter_next     = enter_counter;
    release_counter_next   = release_counter;
    direction_counter_next = direction_counter;
    decrease_counter_next  = decrease_counter;
    if (inhibit) begin
      // force none, keep counters
      held_next = '0;
    end else if (held.shift_side == SIDE_NONE && cand.side == SIDE_NONE) begin
      enter_counter_next     = '0;
      release_counter_next   = '0;
      direction_counter_next = '0;
      decrease_counter_next  = '0;
      held_next              = '0;
    end else if (held.shift_side == SIDE_NONE) begin
      release_counter_next   = '0;
      direction_counter_next = '0;
      decrease_counter_next  = '0;
      enter_counter_next     = enter_bump;
      if (enter_bump > CNT_W'(cfg.enter_threshold)) begin
        held_next          = '{shift_side: cand.side, shift_mm: cand.distance,
                               obstacle_id: cand.id};
        enter_counter_next = '0;
      end
    end else if (cand.side == SIDE_NONE) begin
      enter_counter_next     = '0;
      direction_counter_next = '0;
      decrease_counter_next  = '0;
      release_counter_next   = release_bump;
      if (release_bump > CNT_W'(cfg.release_threshold)) begin
        held_next            = '0;
        release_counter_next = '0;
      end
    end else begin
      enter_counter_next   = '0;
      release_counter_next = '0;
      if (cand.side != held.shift_side) begin
        decrease_counter_next  = '0;
        direction_counter_next = direction_bump;
        if (direction_bump > CNT_W'(cfg.direction_threshold)) begin
          held_next              = '{shift_side: cand.side, shift_mm: cand.distance,
                                     obstacle_id: cand.id};
          direction_counter_next = '0;
        end
      end else if (cand.distance < held.shift_mm) begin
        direction_counter_next = '0;
        decrease_counter_next  = decrease_bump;
        if (decrease_bump > CNT_W'(cfg.decrease_threshold)) begin
          held_next.shift_mm    = cand.distance;
          held_next.obstacle_id = cand.id;
          decrease_counter_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held              <= '0;
      enter_counter     <= '0;
      release_counter   <= '0;
      direction_counter <= '0;
      decrease_counter  <= '0;
    end else if (advance) begin
      held              <= held_next;
      enter_counter     <= enter_counter_next;
      release_counter   <= release_counter_next;
      direction_counter <= direction_counter_next;
      decrease_counter  <= decrease_counter_next;
    end
  end

endmodule

### rtl/lateral_shift_hysteresis_arbiter_top.sv
// Lateral shift hysteresis arbiter: input register, decision logic, held status.
//
// Each transfer on the item channel is one planning cycle and yields exactly one
// transfer on the result channel, carrying the held shift side, distance and
// target after the update. The item is registered, then the per-side shift,
// candidate choice and debounce counter update run combinationally and land in
// the held status registers, which are also the result register. A new item is
// taken every cycle unless the result channel stalls; the result is offered
// from the held status registers once its item has passed the input register.
// The input register keeps accepting while one result waits under stall, so
// only a second stalled item holds off the item channel.
module lateral_shift_hysteresis_arbiter_top import lshar_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  in_item_t          item,
  output logic              result_valid,
  input  logic              result_stall,
  output out_item_t         result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t     cfg;
  cand_t    cand;
  in_item_t item_reg;
  logic     item_full;
  logic     advance;
  logic     take;

  // Advance the registered item when the result slot is free or being emptied.
  assign advance    = item_full && (!result_valid || !result_stall);
  assign item_stall = item_full && !advance;
  assign take       = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (take) begin
        item_full <= 1'b1;
      end else if (advance) begin
        item_full <= 1'b0;
      end
      if (advance) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_reg <= item;
    end
  end

  lshar_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lshar_cand u_cand (
    .item (item_reg),
    .cfg  (cfg),
    .cand (cand)
  );

  lshar_debounce u_debounce (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .inhibit (item_reg.inhibit),
    .cand    (cand),
    .cfg     (cfg),
    .held    (result)
  );

endmodule

### rtl/lshar_checker.sv
// Port-level checker for the lateral shift hysteresis arbiter, with its bind.
`include "lateral_shift_hysteresis_arbiter_top_defines.svh"

module lshar_checker import lshar_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      result_valid,
  input logic      result_stall,
  input out_item_t result
);

  `LSHAR_ASSERT(a_result_hold, result_valid && result_stall |=> result_valid && $stable(result), "stalled result changed or dropped")
  `LSHAR_ASSERT_RST(a_none_is_zero, result.shift_side == SIDE_NONE |-> result.shift_mm == '0 && result.obstacle_id == '0, "no shift side but distance or target nonzero")
  `LSHAR_ASSERT_RST(a_reset_empty, rst |=> !result_valid, "result valid right after reset")

endmodule

bind lateral_shift_hysteresis_arbiter_top lshar_checker u_lshar_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

### sim/testbench.sv
// Self-checking testbench of the lateral shift hysteresis arbiter: randomised runs checked against a predictor.
module testbench;
  import lshar_pkg::*;

  localparam int QUIET_LIMIT      = 2000;
  localparam int LONG_HOLD_CYCLES = 200;
  localparam int MAX_REPORTS      = 10;

  // Addresses with no register behind them
  localparam logic [2:0] REG_UNUSED_A = 3'd6;
  localparam logic [2:0] REG_UNUSED_B = 3'd7;

  typedef enum int {RUN_QUIET, RUN_LEFT, RUN_RIGHT, RUN_BOTH} run_kind_t;

  class shift_status_tracker;
    cfg_t              cfg;
    logic [1:0]        held_side;
    logic [DIST_W-1:0] held_dist;
    logic [ID_W-1:0]   held_target;
    int                enter_cnt, release_cnt, direction_cnt, decrease_cnt;
    out_item_t         expected_status_q[$];
    int                failures;

    function new();
      cfg.safety_margin_mm    = MARGIN_W'(500);
      cfg.max_shift_mm        = DIST_W'(300);
      cfg.enter_threshold     = THR_W'(5);
      cfg.release_threshold   = THR_W'(10);
      cfg.direction_threshold = THR_W'(5);
      cfg.decrease_threshold  = THR_W'(5);
      set_held(SIDE_NONE, 0, '0);
      enter_cnt = 0;
      release_cnt = 0;
      direction_cnt = 0;
      decrease_cnt = 0;
      failures = 0;
    endfunction

    function void write_register(logic [2:0] index, logic [DATA_W-1:0] value);
      case (index)
        REG_SAFETY_MARGIN: cfg.safety_margin_mm    = value[MARGIN_W-1:0];
        REG_MAX_SHIFT:     cfg.max_shift_mm        = value[DIST_W-1:0];
        REG_ENTER_THR:     cfg.enter_threshold     = value[THR_W-1:0];
        REG_RELEASE_THR:   cfg.release_threshold   = value[THR_W-1:0];
        REG_DIRECTION_THR: cfg.direction_threshold = value[THR_W-1:0];
        REG_DECREASE_THR:  cfg.decrease_threshold  = value[THR_W-1:0];
        default: ;
      endcase
    endfunction

    function void set_held(logic [1:0] side, int distance, logic [ID_W-1:0] target);
      held_side   = side;
      held_dist   = distance[DIST_W-1:0];
      held_target = target;
    endfunction

    function int bump(int count);
      return (count < int'(CNT_MAX)) ? count + 1 : int'(CNT_MAX);
    endfunction

    // Margin minus gap, clamped to 0..max
    function int shift_for(logic signed [GAP_W-1:0] gap);
      int s;
      s = int'(cfg.safety_margin_mm) - int'(gap);
      if (s > int'(cfg.max_shift_mm)) s = int'(cfg.max_shift_mm);
      if (s < 0) s = 0;
      return s;
    endfunction

    function void note_plan_input(in_item_t it);
      int              ls, rs, cdist, floor_mm;
      logic [1:0]      cside;
      logic [ID_W-1:0] cid;
      out_item_t       status;
      ls = shift_for(it.left_gap_mm);
      rs = shift_for(it.right_gap_mm);
      floor_mm = int'(MIN_SHIFT_MM);
      cside = SIDE_NONE;
      cdist = 0;
      cid = '0;
      if (it.inhibit) begin
        set_held(SIDE_NONE, 0, '0);
      end else begin
        if (ls > floor_mm && rs <= floor_mm) begin
          cside = SIDE_LEFT;
          cdist = ls;
          cid = it.left_obstacle;
        end else if (rs > floor_mm && ls <= floor_mm) begin
          cside = SIDE_RIGHT;
          cdist = rs;
          cid = it.right_obstacle;
        end
        if (held_side == SIDE_NONE && cside == SIDE_NONE) begin
          enter_cnt = 0;
          release_cnt = 0;
          direction_cnt = 0;
          decrease_cnt = 0;
          set_held(SIDE_NONE, 0, '0);
        end else if (held_side == SIDE_NONE) begin
          release_cnt = 0;
          direction_cnt = 0;
          decrease_cnt = 0;
          enter_cnt = bump(enter_cnt);
          if (enter_cnt > int'(cfg.enter_threshold)) begin
            set_held(cside, cdist, cid);
            enter_cnt = 0;
          end
        end else if (cside == SIDE_NONE) begin
          enter_cnt = 0;
          direction_cnt = 0;
          decrease_cnt = 0;
          release_cnt = bump(release_cnt);
          if (release_cnt > int'(cfg.release_threshold)) begin
            set_held(SIDE_NONE, 0, '0);
            release_cnt = 0;
          end
        end else begin
          enter_cnt = 0;
          release_cnt = 0;
          if (cside != held_side) begin
            decrease_cnt = 0;
            direction_cnt = bump(direction_cnt);
            if (direction_cnt > int'(cfg.direction_threshold)) begin
              set_held(cside, cdist, cid);
              direction_cnt = 0;
            end
          end else if (cdist < int'(held_dist)) begin
            direction_cnt = 0;
            decrease_cnt = bump(decrease_cnt);
            if (decrease_cnt > int'(cfg.decrease_threshold)) begin
              set_held(held_side, cdist, cid);
              decrease_cnt = 0;
            end
          end
          // same side, distance not smaller: keep status and the direction and decrease counters
        end
      end
      status.shift_side  = held_side;
      status.shift_mm    = held_dist;
      status.obstacle_id = held_target;
      expected_status_q.push_back(status);
    endfunction

    function void check_status(out_item_t got);
      out_item_t want;
      if (expected_status_q.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected result: side %0d mm %0d id %0d",
                   got.shift_side, got.shift_mm, got.obstacle_id);
        return;
      end
      want = expected_status_q.pop_front();
      if (got.shift_side !== want.shift_side || got.shift_mm !== want.shift_mm ||
          got.obstacle_id !== want.obstacle_id) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("status mismatch: expected side %0d mm %0d id %0d, %s %0d mm %0d id %0d",
                   want.shift_side, want.shift_mm, want.obstacle_id, "got side",
                   got.shift_side, got.shift_mm, got.obstacle_id);
      end
    endfunction

    function int pending();
      return expected_status_q.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_stall;
  in_item_t          item = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  out_item_t         result;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  shift_status_tracker status_tracker = new();

  bit              no_idle = 1'b0;
  bit              long_hold_req = 1'b0;
  bit              noise_on = 1'b1;
  run_kind_t       run_kind = RUN_QUIET;
  int              run_left = 0;
  int              run_dist = 11;
  int              run_trend = 0;
  int              run_len_min = 1;
  int              run_len_max = 8;
  logic [ID_W-1:0] run_id = '0;
  int              quiet_cycles = 0;

  lateral_shift_hysteresis_arbiter_top DUT (
    .clk, .rst, .item_valid, .item_stall, .item, .result_valid, .result_stall, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #4 clk = ~clk;

  // End the run when nothing has been transferred for too long
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic in_item_t plan_input(logic inh, logic signed [GAP_W-1:0] lgap,
                                          logic signed [GAP_W-1:0] rgap,
                                          logic [ID_W-1:0] lid, logic [ID_W-1:0] rid);
    in_item_t it;
    it.inhibit        = inh;
    it.left_gap_mm    = lgap;
    it.right_gap_mm   = rgap;
    it.left_obstacle  = lid;
    it.right_obstacle = rid;
    return it;
  endfunction

  // Gap that gives a shift of 10 mm or less
  function automatic logic signed [GAP_W-1:0] cold_gap(int margin);
    case ($urandom_range(0, 2))
      0:       return 16'sh7FFF;
      1:       return GAP_W'(margin - int'($urandom_range(0, 10)));
      default: return GAP_W'(margin + int'($urandom_range(1, 27000)));
    endcase
  endfunction

  function automatic in_item_t next_item();
    in_item_t    it;
    logic [95:0] raw;
    int          margin, max_shift;
    logic signed [GAP_W-1:0] hot_gap;
    margin = int'(status_tracker.cfg.safety_margin_mm);
    max_shift = int'(status_tracker.cfg.max_shift_mm);
    raw = {$urandom, $urandom, $urandom};
    it = raw[64:0];
    if (noise_on && $urandom_range(0, 11) == 0) return it;
    if (run_left == 0) begin
      run_left = $urandom_range(run_len_min, run_len_max);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: run_kind = RUN_LEFT;
        4, 5, 6:    run_kind = RUN_RIGHT;
        7:          run_kind = RUN_BOTH;
        default:    run_kind = RUN_QUIET;
      endcase
      run_dist = $urandom_range(11, max_shift + 200);
      run_trend = $urandom_range(0, 3);
      run_id = ID_W'($urandom);
    end
    run_left--;
    case (run_trend)
      1: if (run_dist > 31) run_dist = run_dist - int'($urandom_range(0, 20));
      2: run_dist = run_dist + int'($urandom_range(0, 20));
      3: run_dist = $urandom_range(11, max_shift + 200);
      default: ;
    endcase
    if ($urandom_range(0, 7) == 0) run_id = ID_W'($urandom);
    it.inhibit = ($urandom_range(0, 24) == 0);
    hot_gap = GAP_W'(margin - run_dist);
    case (run_kind)
      RUN_LEFT: begin
        it.left_gap_mm = hot_gap;
        it.right_gap_mm = cold_gap(margin);
        it.left_obstacle = run_id;
      end
      RUN_RIGHT: begin
        it.left_gap_mm = cold_gap(margin);
        it.right_gap_mm = hot_gap;
        it.right_obstacle = run_id;
      end
      RUN_BOTH: begin
        it.left_gap_mm = hot_gap;
        it.right_gap_mm = GAP_W'(margin - int'($urandom_range(11, max_shift + 200)));
      end
      default: begin
        it.left_gap_mm = cold_gap(margin);
        it.right_gap_mm = cold_gap(margin);
      end
    endcase
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    status_tracker.note_plan_input(it);
  endtask

  // Leaves psel high so that writes follow back to back
  task automatic apb_write(input logic [2:0] index, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    status_tracker.write_register(index, value);
  endtask

  task automatic configure(input int margin, input int max_shift, input int enter_thr,
                           input int release_thr, input int direction_thr,
                           input int decrease_thr);
    item_valid <= 1'b0;
    while (status_tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    apb_write(REG_SAFETY_MARGIN, margin);
    apb_write(REG_MAX_SHIFT, max_shift);
    apb_write(REG_ENTER_THR, enter_thr);
    apb_write(REG_RELEASE_THR, release_thr);
    apb_write(REG_DIRECTION_THR, direction_thr);
    apb_write(REG_DECREASE_THR, decrease_thr);
    apb_write($urandom_range(0, 1) ? REG_UNUSED_A : REG_UNUSED_B, $urandom);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input int count, input int len_min, input int len_max,
                           input bit noisy, input int hold_at);
    run_len_min = len_min;
    run_len_max = len_max;
    noise_on = noisy;
    run_left = 0;
    no_idle = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) long_hold_req = 1'b1;
      send_item(next_item());
    end
    no_idle = 1'b0;
  endtask

  // Result side: random stall before each transfer, one long hold on request
  initial begin
    int n;
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        n = LONG_HOLD_CYCLES;
      end else begin
        n = no_idle ? 0 : $urandom_range(0, 7);
      end
      if (n > 0) begin
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
      status_tracker.check_status(result);
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: no obstacle, both sides dangerous, exactly 10 mm, adopt, inhibit
    send_item(plan_input(1'b0, 16'sh7FFF, 16'sh7FFF, 16'h0000, 16'h0000));
    send_item(plan_input(1'b0, 16'sh8000, 16'sh8000, 16'hFFFF, 16'hFFFF));
    send_item(plan_input(1'b0, 16'sd490, 16'sh7FFF, 16'h0001, 16'h0002));
    repeat (7) send_item(plan_input(1'b0, 16'sh8000, 16'sh7FFF, 16'hFFFF, 16'h0005));
    send_item(plan_input(1'b1, 16'sh8000, 16'sh7FFF, 16'hFFFF, 16'h0005));
    repeat (7) send_item(plan_input(1'b0, 16'sh7FFF, 16'sd489, 16'h0003, 16'hFFFF));
    repeat (3) send_item(plan_input(1'b0, 16'sd0, 16'sh7FFF, 16'h0007, 16'h0000));
    repeat (3) send_item(plan_input(1'b0, 16'sh7FFF, 16'sh7FFF, 16'h0000, 16'h0000));

    configure(0, 0, 0, 0, 0, 0);
    run_phase(40, 1, 8, 1'b1, -1);
    configure(5000, 2000, 0, 0, 0, 0);
    run_phase(120, 1, 6, 1'b1, -1);
    // Thresholds at the top: runs often long enough to pass them, no noise to break them
    configure(5000, 2000, 255, 255, 255, 255);
    run_phase(560, 250, 300, 1'b0, -1);
    for (int p = 0; p < 5; p++) begin
      configure($urandom_range(0, 5000), $urandom_range(20, 2000), $urandom_range(0, 10),
                $urandom_range(0, 10), $urandom_range(0, 10), $urandom_range(0, 10));
      run_phase(100, 1, 16, 1'b1, (p == 2) ? 50 : -1);
    end

    item_valid <= 1'b0;
    while (status_tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (status_tracker.failures == 0 && status_tracker.pending() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
